// File: rtl/assert_macros.svh
// Assertion macros shared by the slot allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition a implies condition c in the same cycle.
`define ASSERT_SAME(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// Condition a implies condition c in the following cycle.
`define ASSERT_NEXT(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

// Condition c holds at every sampled edge.
`define ASSERT_ALWAYS(label, clk, rst, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (c)) else $error(msg);

`endif

// File: rtl/ssba_pkg.sv
// Package with the types, codes and constants of the slot allocator.
package ssba_pkg;

   localparam int FIELD_W       = 12;
   localparam int CTR_W         = 32;
   localparam int MAX_SLOTS_DEF = 4096;
   localparam int MAP_ROW_BITS  = 64;
   localparam int WORD_BITS_DEF = MAP_ROW_BITS;

   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_FREE    = 2'd1;
   localparam logic [1:0] OP_ENABLE  = 2'd2;
   localparam logic [1:0] OP_DISABLE = 2'd3;

   localparam logic [2:0] STATUS_OK      = 3'd0;
   localparam logic [2:0] STATUS_NO_AREA = 3'd1;
   localparam logic [2:0] STATUS_FULL    = 3'd2;
   localparam logic [2:0] STATUS_INVALID = 3'd3;
   localparam logic [2:0] STATUS_BUSY    = 3'd4;
   localparam logic [2:0] STATUS_IGNORED = 3'd5;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_FREE_SEEK,
      S_FREE_UPD,
      S_BUILD
   } state_type;

   typedef struct packed {
      logic [1:0]         op;
      logic [FIELD_W-1:0] slot;
      logic [FIELD_W-1:0] size_slots;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [FIELD_W-1:0] granted_slot;
      logic [FIELD_W-1:0] slots_in_use;
      logic [FIELD_W-1:0] area_slots;
      logic               pager_on;
      logic               draining;
      logic [CTR_W-1:0]   full_refusals;
      logic [CTR_W-1:0]   no_area_refusals;
   } rsp_type;

endpackage

// File: rtl/ssba_map_ram.sv
// Free-slot bitmap memory: one write port, one read port with registered data.
module ssba_map_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/ssba_ffs.sv
// Find-first-set unit: lowest set bit of one bitmap row.
module ssba_ffs #(
   parameter int WIDTH = 64
) (
   input  logic [WIDTH-1:0]         data,
   output logic                     found,
   output logic [$clog2(WIDTH)-1:0] index
);

   localparam int IW = $clog2(WIDTH);

   always_comb begin
      index = '0;
      for (int i = WIDTH - 1; i >= 0; i--) begin
         if (data[i]) begin
            index = IW'(i);
         end
      end
   end

   assign found = |data;

endmodule

// File: rtl/swap_slot_bitmap_allocator.sv
// Top level of the next-fit slot allocator: sequencer, row walker and counters.
// Words answered at decode give their result strobe straight from the decode state;
// allocate, free and an enable with a rebuild first step through rows of the map.
// The row walker steps one bitmap row per cycle through the map memory's read port, so
// one word is worked on at a time; the next is taken in the cycle of the strobe.
// Reset is synchronous and clears all control state and counters; the map memory is
// not swept, since it is rewritten in full before any row of it is read.
`include "assert_macros.svh"

module swap_slot_bitmap_allocator #(
   parameter int MAX_SLOTS = ssba_pkg::MAX_SLOTS_DEF,
   parameter int WORD_BITS = ssba_pkg::WORD_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ssba_pkg::req_type req_data,
   output logic              rsp_strobe,
   output ssba_pkg::rsp_type rsp_data
);

   // Derived sizes. Slot numbers need IDX_W bits; the slot count, which may reach
   // MAX_SLOTS itself, needs one more. Comparisons against the 12-bit fields of a
   // word are made at EXT_W bits so that nothing is lost at either extreme.
   localparam int FW        = ssba_pkg::FIELD_W;
   localparam int CW        = ssba_pkg::CTR_W;
   localparam int MAP_WORDS = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
   localparam int WADDR_W   = $clog2(MAP_WORDS);
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int IDX_W     = $clog2(MAX_SLOTS);
   localparam int CNT_W     = IDX_W + 1;
   localparam int EXT_W     = (CNT_W > FW + 1) ? CNT_W : FW + 1;
   localparam int K_W       = $clog2(MAP_WORDS + 2);

   // Sequencer and the request being served.
   ssba_pkg::state_type state_ff, state_in;
   ssba_pkg::req_type   req_ff, req_in;

   // Allocator state proper.
   logic               area_ff, area_in;
   logic               enabled_ff, enabled_in;
   logic [CNT_W-1:0]   slot_count_ff, slot_count_in;
   logic [IDX_W-1:0]   used_ff, used_in;
   logic [IDX_W-1:0]   rover_ff, rover_in;
   logic [WADDR_W-1:0] rover_row_ff, rover_row_in;
   logic [BIT_W-1:0]   rover_bit_ff, rover_bit_in;
   logic [CW-1:0]      full_cnt_ff, full_cnt_in;
   logic [CW-1:0]      no_area_cnt_ff, no_area_cnt_in;

   // Row walker: current row, slot number of its bit 0, and visit count.
   logic [WADDR_W-1:0] row_ff, row_in;
   logic [IDX_W-1:0]   base_ff, base_in;
   logic [K_W-1:0]     k_ff, k_in;

   // Copies of the walker that line up with the registered read data.
   logic               d_vld_ff, d_vld_in;
   logic [WADDR_W-1:0] d_row_ff, d_row_in;
   logic [IDX_W-1:0]   d_base_ff, d_base_in;
   logic [K_W-1:0]     d_k_ff, d_k_in;

   logic [BIT_W-1:0]   start_bit_ff, start_bit_in;
   logic [BIT_W-1:0]   bit_ff, bit_in;
   logic [CNT_W-1:0]   new_slots_ff, new_slots_in;

   // Result registers.
   logic               rsp_strobe_ff, rsp_strobe_in;
   logic [2:0]         status_ff, status_in;
   logic [IDX_W-1:0]   granted_ff, granted_in;

   // Memory and search unit connections.
   logic                 wr_en;
   logic [WADDR_W-1:0]   wr_addr;
   logic [WORD_BITS-1:0] wr_data;
   logic [WORD_BITS-1:0] rd_data;
   logic [WORD_BITS-1:0] scan_data;
   logic                 ffs_found;
   logic [BIT_W-1:0]     ffs_idx;

   // Working values.
   localparam logic [WORD_BITS-1:0] ONE = WORD_BITS'(1);
   logic [EXT_W-1:0]     cnt_ext, slot_ext, size_ext, slots_ext, rem_ext;
   logic [EXT_W-1:0]     nb_ext, bb_ext, diff_ext, next_ext;
   logic [WORD_BITS-1:0] low_mask, scan_mask, build_mask;
   logic [IDX_W-1:0]     slot_i, used_dec;
   logic [WADDR_W-1:0]   row_next;
   logic [IDX_W-1:0]     base_next;
   logic                 no_area_clean;

   ssba_map_ram #(
      .DEPTH (MAP_WORDS),
      .WIDTH (WORD_BITS)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (row_ff),
      .rd_data (rd_data)
   );

   ssba_ffs #(
      .WIDTH (WORD_BITS)
   ) u_ffs (
      .data  (scan_data),
      .found (ffs_found),
      .index (ffs_idx)
   );

   // Operand extension and the walker's next-row and next-base arithmetic.
   assign cnt_ext   = EXT_W'(slot_count_ff);
   assign slot_ext  = EXT_W'(req_ff.slot);
   assign size_ext  = EXT_W'(req_ff.size_slots);
   assign slots_ext = size_ext + EXT_W'(1);
   assign rem_ext   = slot_ext - EXT_W'(base_ff);
   assign row_next  = (row_ff == WADDR_W'(MAP_WORDS - 1)) ? '0 : row_ff + WADDR_W'(1);
   assign base_next = (row_ff == WADDR_W'(MAP_WORDS - 1)) ? '0 :
                      base_ff + IDX_W'(WORD_BITS);

   // The first visit of the start row looks only at bits from the rover upwards, and
   // the closing visit of the same row only at the bits below it.
   assign low_mask  = (ONE << start_bit_ff) - ONE;
   always_comb begin
      if (d_k_ff == '0) begin
         scan_mask = ~low_mask;
      end else if (d_k_ff == K_W'(MAP_WORDS)) begin
         scan_mask = low_mask;
      end else begin
         scan_mask = '1;
      end
   end
   assign scan_data = rd_data & scan_mask;

   assign slot_i   = d_base_ff + IDX_W'(ffs_idx);
   assign next_ext = EXT_W'(slot_i) + EXT_W'(1);
   assign used_dec = (used_ff != '0) ? used_ff - IDX_W'(1) : used_ff;

   // Initial contents of one row for a new area: slots 1 to count-1 are free.
   assign nb_ext   = EXT_W'(new_slots_ff);
   assign bb_ext   = EXT_W'(base_ff);
   assign diff_ext = nb_ext - bb_ext;
   always_comb begin
      if (nb_ext <= bb_ext) begin
         build_mask = '0;
      end else if (diff_ext >= EXT_W'(WORD_BITS)) begin
         build_mask = '1;
      end else begin
         build_mask = (ONE << BIT_W'(diff_ext)) - ONE;
      end
      if (base_ff == '0) begin
         build_mask[0] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ssba_pkg::S_IDLE;
         area_ff        <= 1'b0;
         enabled_ff     <= 1'b0;
         slot_count_ff  <= '0;
         used_ff        <= '0;
         rover_ff       <= '0;
         rover_row_ff   <= '0;
         rover_bit_ff   <= '0;
         full_cnt_ff    <= '0;
         no_area_cnt_ff <= '0;
         d_vld_ff       <= 1'b0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         area_ff        <= area_in;
         enabled_ff     <= enabled_in;
         slot_count_ff  <= slot_count_in;
         used_ff        <= used_in;
         rover_ff       <= rover_in;
         rover_row_ff   <= rover_row_in;
         rover_bit_ff   <= rover_bit_in;
         full_cnt_ff    <= full_cnt_in;
         no_area_cnt_ff <= no_area_cnt_in;
         d_vld_ff       <= d_vld_in;
         rsp_strobe_ff  <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      row_ff       <= row_in;
      base_ff      <= base_in;
      k_ff         <= k_in;
      d_row_ff     <= d_row_in;
      d_base_ff    <= d_base_in;
      d_k_ff       <= d_k_in;
      start_bit_ff <= start_bit_in;
      bit_ff       <= bit_in;
      new_slots_ff <= new_slots_in;
      status_ff    <= status_in;
      granted_ff   <= granted_in;
   end

   // Sequencer: decodes a word, then walks the map for allocate, free and an enable that rebuilds it.
   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      area_in        = area_ff;
      enabled_in     = enabled_ff;
      slot_count_in  = slot_count_ff;
      used_in        = used_ff;
      rover_in       = rover_ff;
      rover_row_in   = rover_row_ff;
      rover_bit_in   = rover_bit_ff;
      full_cnt_in    = full_cnt_ff;
      no_area_cnt_in = no_area_cnt_ff;
      row_in         = row_ff;
      base_in        = base_ff;
      k_in           = k_ff;
      d_vld_in       = 1'b0;
      d_row_in       = row_ff;
      d_base_in      = base_ff;
      d_k_in         = k_ff;
      start_bit_in   = start_bit_ff;
      bit_in         = bit_ff;
      new_slots_in   = new_slots_ff;
      rsp_strobe_in  = 1'b0;
      status_in      = status_ff;
      granted_in     = granted_ff;
      wr_en          = 1'b0;
      wr_addr        = row_ff;
      wr_data        = build_mask;

      case (state_ff)
         ssba_pkg::S_IDLE: begin
            if (start) begin
               req_in   = req_data;
               state_in = ssba_pkg::S_DECODE;
            end
         end

         ssba_pkg::S_DECODE: begin
            granted_in = '0;
            case (req_ff.op)
               ssba_pkg::OP_ALLOC: begin
                  if (!enabled_ff || !area_ff || cnt_ext < EXT_W'(2)) begin
                     no_area_cnt_in = no_area_cnt_ff + CW'(1);
                     status_in      = ssba_pkg::STATUS_NO_AREA;
                     rsp_strobe_in  = 1'b1;
                     state_in       = ssba_pkg::S_IDLE;
                  end else begin
                     // A rover outside the area restarts the search at slot 1.
                     if (rover_ff == '0 || EXT_W'(rover_ff) >= cnt_ext) begin
                        row_in       = '0;
                        base_in      = '0;
                        start_bit_in = BIT_W'(1);
                     end else begin
                        row_in       = rover_row_ff;
                        base_in      = rover_ff - IDX_W'(rover_bit_ff);
                        start_bit_in = rover_bit_ff;
                     end
                     k_in     = '0;
                     state_in = ssba_pkg::S_SCAN;
                  end
               end

               ssba_pkg::OP_FREE: begin
                  if (req_ff.slot == '0 || !area_ff || slot_ext >= cnt_ext) begin
                     status_in     = ssba_pkg::STATUS_IGNORED;
                     rsp_strobe_in = 1'b1;
                     state_in      = ssba_pkg::S_IDLE;
                  end else begin
                     row_in   = '0;
                     base_in  = '0;
                     state_in = ssba_pkg::S_FREE_SEEK;
                  end
               end

               ssba_pkg::OP_ENABLE: begin
                  new_slots_in = CNT_W'(slots_ext);
                  row_in       = '0;
                  base_in      = '0;
                  if (req_ff.size_slots == '0 || slots_ext > EXT_W'(MAX_SLOTS)) begin
                     status_in     = ssba_pkg::STATUS_INVALID;
                     rsp_strobe_in = 1'b1;
                     state_in      = ssba_pkg::S_IDLE;
                  end else if (area_ff && !enabled_ff) begin
                     status_in     = ssba_pkg::STATUS_BUSY;
                     rsp_strobe_in = 1'b1;
                     state_in      = ssba_pkg::S_IDLE;
                  end else if (area_ff && cnt_ext == slots_ext) begin
                     status_in     = ssba_pkg::STATUS_OK;
                     rsp_strobe_in = 1'b1;
                     state_in      = ssba_pkg::S_IDLE;
                  end else if (area_ff && used_ff != '0) begin
                     // A resize with slots still out leaves the old area draining.
                     enabled_in    = 1'b0;
                     status_in     = ssba_pkg::STATUS_BUSY;
                     rsp_strobe_in = 1'b1;
                     state_in      = ssba_pkg::S_IDLE;
                  end else begin
                     state_in = ssba_pkg::S_BUILD;
                  end
               end

               ssba_pkg::OP_DISABLE: begin
                  enabled_in    = 1'b0;
                  rsp_strobe_in = 1'b1;
                  state_in      = ssba_pkg::S_IDLE;
                  if (!area_ff) begin
                     status_in = ssba_pkg::STATUS_IGNORED;
                  end else begin
                     status_in = ssba_pkg::STATUS_OK;
                     if (used_ff == '0) begin
                        area_in       = 1'b0;
                        slot_count_in = '0;
                        used_in       = '0;
                        rover_in      = '0;
                        rover_row_in  = '0;
                        rover_bit_in  = '0;
                     end
                  end
               end

               default: begin
                  state_in = ssba_pkg::S_IDLE;
               end
            endcase
         end

         ssba_pkg::S_SCAN: begin
            // One row is requested per cycle; the row whose read data has just arrived is examined.
            row_in   = row_next;
            base_in  = base_next;
            k_in     = k_ff + K_W'(1);
            d_vld_in = (k_ff <= K_W'(MAP_WORDS));
            if (d_vld_ff && ffs_found) begin
               wr_en          = 1'b1;
               wr_addr        = d_row_ff;
               wr_data        = rd_data & ~(ONE << ffs_idx);
               used_in        = used_ff + IDX_W'(1);
               granted_in     = slot_i;
               status_in      = ssba_pkg::STATUS_OK;
               rsp_strobe_in  = 1'b1;
               state_in       = ssba_pkg::S_IDLE;
               if (next_ext >= cnt_ext) begin
                  rover_in     = IDX_W'(1);
                  rover_row_in = '0;
                  rover_bit_in = BIT_W'(1);
               end else begin
                  rover_in = IDX_W'(next_ext);
                  if (ffs_idx == BIT_W'(WORD_BITS - 1)) begin
                     rover_row_in = d_row_ff + WADDR_W'(1);
                     rover_bit_in = '0;
                  end else begin
                     rover_row_in = d_row_ff;
                     rover_bit_in = ffs_idx + BIT_W'(1);
                  end
               end
            end else if (d_vld_ff && d_k_ff == K_W'(MAP_WORDS)) begin
               full_cnt_in   = full_cnt_ff + CW'(1);
               status_in     = ssba_pkg::STATUS_FULL;
               rsp_strobe_in = 1'b1;
               state_in      = ssba_pkg::S_IDLE;
            end
         end

         ssba_pkg::S_FREE_SEEK: begin
            // Step row by row until the slot falls inside the current row.
            if (rem_ext < EXT_W'(WORD_BITS)) begin
               bit_in   = BIT_W'(rem_ext);
               state_in = ssba_pkg::S_FREE_UPD;
            end else begin
               row_in  = row_next;
               base_in = base_next;
            end
         end

         ssba_pkg::S_FREE_UPD: begin
            rsp_strobe_in = 1'b1;
            state_in      = ssba_pkg::S_IDLE;
            if (!rd_data[bit_ff]) begin
               wr_en        = 1'b1;
               wr_data      = rd_data | (ONE << bit_ff);
               used_in      = used_dec;
               rover_in     = IDX_W'(slot_ext);
               rover_row_in = row_ff;
               rover_bit_in = bit_ff;
               status_in    = ssba_pkg::STATUS_OK;
            end else begin
               status_in = ssba_pkg::STATUS_IGNORED;
            end
            // The last slot back from a disabled area releases it.
            if (used_in == '0 && !enabled_ff) begin
               area_in       = 1'b0;
               slot_count_in = '0;
               used_in       = '0;
               rover_in      = '0;
               rover_row_in  = '0;
               rover_bit_in  = '0;
            end
         end

         ssba_pkg::S_BUILD: begin
            wr_en   = 1'b1;
            row_in  = row_next;
            base_in = base_next;
            if (row_ff == WADDR_W'(MAP_WORDS - 1)) begin
               area_in       = 1'b1;
               enabled_in    = 1'b1;
               slot_count_in = new_slots_ff;
               used_in       = '0;
               rover_in      = IDX_W'(1);
               rover_row_in  = '0;
               rover_bit_in  = BIT_W'(1);
               status_in     = ssba_pkg::STATUS_OK;
               rsp_strobe_in = 1'b1;
               state_in      = ssba_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = ssba_pkg::S_IDLE;
         end
      endcase
   end

   // Outputs. The result fields come straight from registers.
   assign busy       = (state_ff != ssba_pkg::S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;

   always_comb begin
      rsp_data.status           = status_ff;
      rsp_data.granted_slot     = FW'(EXT_W'(granted_ff));
      rsp_data.slots_in_use     = FW'(EXT_W'(used_ff));
      rsp_data.area_slots       = (slot_count_ff == '0) ? '0 :
                                  FW'(EXT_W'(slot_count_ff - CNT_W'(1)));
      rsp_data.pager_on         = enabled_ff;
      rsp_data.draining         = area_ff && !enabled_ff;
      rsp_data.full_refusals    = full_cnt_ff;
      rsp_data.no_area_refusals = no_area_cnt_ff;
   end

   // Without an area nothing may be left in use, counted or enabled.
   assign no_area_clean = (used_ff == '0) && (slot_count_ff == '0) && !enabled_ff;

   `ASSERT_SAME(a_strobe_idle, clock, reset, rsp_strobe_ff, !busy, "strobe while busy")
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy && !rsp_strobe_ff, "not busy")
   `ASSERT_NEXT(a_single_strobe, clock, reset, rsp_strobe_ff, !rsp_strobe_ff, "double strobe")
   `ASSERT_ALWAYS(a_no_area_empty, clock, reset, area_ff || no_area_clean, "stale area state")
   `ASSERT_ALWAYS(a_used_ok, clock, reset, !area_ff || EXT_W'(used_ff) < cnt_ext, "used too high")

endmodule
